// ----- src/kmsd_pkg.sv -----
// Shared constants, types and the keymap of the key matrix scanner.
package kmsd_pkg;

   localparam int NUM_ROWS         = 6;
   localparam int NUM_COLS         = 6;
   localparam int NUM_SLOTS        = 6;
   localparam int SAMPLE_COUNT_DEF = 4;

   localparam logic [5:0] ROW_MASK       = 6'h3f;
   localparam int         ARROW_COL      = 5;
   localparam logic [2:0] ALT_KEY_ROW    = 3'd5;
   localparam logic [2:0] UP_KEY_ROW     = 3'd2;
   localparam logic [2:0] DOWN_KEY_ROW   = 3'd0;
   localparam logic [2:0] LEFT_KEY_ROW   = 3'd1;
   localparam logic [2:0] RIGHT_KEY_ROW  = 3'd3;
   localparam logic [7:0] ROLLOVER_CODE  = 8'h01;

   localparam logic [1:0] CMD_SCAN   = 2'd0;
   localparam logic [1:0] CMD_REPORT = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   typedef struct packed {
      logic [2:0] active_row;
      logic [5:0] row_bits;
      logic [7:0] modifier;
      logic [7:0] key_slot0;
      logic [7:0] key_slot1;
      logic [7:0] key_slot2;
      logic [7:0] key_slot3;
      logic [7:0] key_slot4;
      logic [7:0] key_slot5;
   } rsp_data_type;

   // Each line packs the six keycodes of one row, column 0 in the low byte.
   function automatic logic [7:0] keymap_code(input logic layer, input logic [2:0] row,
                                              input logic [2:0] col);
      logic [47:0] line;
      begin
         unique case ({layer, row})
            4'h0:    line = 48'h51_05_11_10_36_2C;
            4'h1:    line = 48'h50_0B_0D_0E_0F_28;
            4'h2:    line = 48'h52_1C_18_0C_12_13;
            4'h3:    line = 48'h4F_19_06_1B_1D_2A;
            4'h4:    line = 48'h29_0A_09_07_16_04;
            4'h5:    line = 48'hE2_17_15_08_1A_14;
            4'h8:    line = 48'h51_05_11_10_33_2C;
            4'h9:    line = 48'h50_0B_0D_0E_2D_28;
            4'hA:    line = 48'h52_23_24_25_26_27;
            4'hB:    line = 48'h4F_19_06_1B_1D_2E;
            4'hC:    line = 48'h39_0A_09_07_16_04;
            4'hD:    line = 48'hE2_22_21_20_1F_1E;
            default: line = 48'h0;
         endcase
         return (col < 3'(NUM_COLS)) ? line[col*8 +: 8] : 8'h00;
      end
   endfunction

endpackage

// ----- src/kmsd_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
interface kmsd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [5:0] column_levels;
   logic [2:0] row_select;

   modport source (output valid, output cmd, output column_levels, output row_select,
                   input ready);
   modport sink (input valid, input cmd, input column_levels, input row_select,
                 output ready);
endinterface

interface kmsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] active_row;
   logic [5:0] row_bits;
   logic [7:0] modifier;
   logic [7:0] key_slot0;
   logic [7:0] key_slot1;
   logic [7:0] key_slot2;
   logic [7:0] key_slot3;
   logic [7:0] key_slot4;
   logic [7:0] key_slot5;

   modport source (output valid, output active_row, output row_bits, output modifier,
                   output key_slot0, output key_slot1, output key_slot2,
                   output key_slot3, output key_slot4, output key_slot5, input ready);
   modport sink (input valid, input active_row, input row_bits, input modifier,
                 input key_slot0, input key_slot1, input key_slot2,
                 input key_slot3, input key_slot4, input key_slot5, output ready);
endinterface

// ----- src/kmsd_sample_mem.sv -----
// Sample store: one write port and one registered read port.
module kmsd_sample_mem #(
   parameter int DEPTH = 24,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [5:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [5:0]    rd_data
);
   logic [5:0] mem [DEPTH];
   logic [5:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/kmsd_ctrl.sv -----
// Sequencer and shared datapath: sample debounce, alt commands and report build.
module kmsd_ctrl #(
   parameter int SAMPLE_COUNT = kmsd_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   kmsd_req_if.sink              req,
   output logic                  res_valid,
   input  logic                  res_ready,
   output kmsd_pkg::rsp_data_type res_data
);
   import kmsd_pkg::*;

   localparam int DEPTH = NUM_ROWS * SAMPLE_COUNT;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RD    = 3'd2;
   localparam logic [2:0] ST_FIN   = 3'd3;
   localparam logic [2:0] ST_WALK  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [2:0]    row_ff, row_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [SW-1:0] k_ff, k_in;
   logic          pend_ff;
   logic [5:0]    any_ff, any_in;
   logic [5:0]    all_ff, all_in;
   logic [5:0]    deb_ff [NUM_ROWS];
   logic [5:0]    deb_in [NUM_ROWS];
   logic          shift_ff, shift_in;
   logic          layer_ff, layer_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic [5:0]    bits_ff, bits_in;
   logic [2:0]    walk_ff, walk_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic          over_ff, over_in;
   logic [7:0]    key_ff [NUM_SLOTS];
   logic [7:0]    key_in [NUM_SLOTS];

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [5:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [5:0]    mem_rdata;

   logic [2:0]    deb_sel;
   logic [5:0]    deb_rd;
   logic [5:0]    any_fin, all_fin, deb_new;
   logic [2:0]    n_v;
   logic          ov_v;
   logic          accept;

   kmsd_sample_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && (state_ff == ST_IDLE);

   // One read port into the debounced rows, steered by the sequencer.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: deb_sel = req.row_select;
         ST_WALK: deb_sel = walk_ff;
         default: deb_sel = row_ff;
      endcase
      deb_rd = (deb_sel < 3'(NUM_ROWS)) ? deb_ff[deb_sel] : 6'h00;
   end

   assign any_fin = any_ff | mem_rdata;
   assign all_fin = all_ff & mem_rdata;
   assign deb_new = (all_fin | deb_rd) & any_fin & ROW_MASK;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      row_in      = row_ff;
      slot_in     = slot_ff;
      k_in        = k_ff;
      any_in      = any_ff;
      all_in      = all_ff;
      deb_in      = deb_ff;
      shift_in    = shift_ff;
      layer_in    = layer_ff;
      cmd_in      = cmd_ff;
      bits_in     = bits_ff;
      walk_in     = walk_ff;
      cnt_in      = cnt_ff;
      over_in     = over_ff;
      key_in      = key_ff;
      mem_we      = 1'b0;
      mem_waddr   = clr_addr_ff;
      mem_wdata   = 6'h00;
      mem_raddr   = AW'(row_ff) * AW'(SAMPLE_COUNT) + AW'(k_ff);
      n_v         = cnt_ff;
      ov_v        = over_ff;
      res_valid   = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req.cmd;
               unique case (req.cmd)
                  CMD_SCAN: begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(row_ff) * AW'(SAMPLE_COUNT) + AW'(slot_ff);
                     mem_wdata = ~req.column_levels & ROW_MASK;
                     if (row_ff == 3'(NUM_ROWS - 1)) begin
                        row_in  = 3'd0;
                        slot_in = (slot_ff == SW'(SAMPLE_COUNT - 1)) ? '0 : slot_ff + 1'b1;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                     k_in     = '0;
                     any_in   = 6'h00;
                     all_in   = ROW_MASK;
                     state_in = ST_RD;
                  end
                  CMD_REPORT: begin
                     // Alt plus an arrow acts as a command and the arrows are dropped.
                     if (deb_ff[ALT_KEY_ROW][ARROW_COL]) begin
                        if (deb_ff[UP_KEY_ROW][ARROW_COL]) begin
                           shift_in = 1'b1;
                        end else if (deb_ff[DOWN_KEY_ROW][ARROW_COL]) begin
                           shift_in = 1'b0;
                        end
                        if (deb_ff[RIGHT_KEY_ROW][ARROW_COL]) begin
                           layer_in = 1'b1;
                        end else if (deb_ff[LEFT_KEY_ROW][ARROW_COL]) begin
                           layer_in = 1'b0;
                        end
                        deb_in[UP_KEY_ROW][ARROW_COL]    = 1'b0;
                        deb_in[DOWN_KEY_ROW][ARROW_COL]  = 1'b0;
                        deb_in[RIGHT_KEY_ROW][ARROW_COL] = 1'b0;
                        deb_in[LEFT_KEY_ROW][ARROW_COL]  = 1'b0;
                     end
                     walk_in  = 3'd0;
                     cnt_in   = 3'd0;
                     over_in  = 1'b0;
                     for (int s = 0; s < NUM_SLOTS; s++) begin
                        key_in[s] = 8'h00;
                     end
                     state_in = ST_WALK;
                  end
                  CMD_READ: begin
                     bits_in  = deb_rd;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RD: begin
            // Read data is registered behind its address, so accumulate one sample behind.
            if (pend_ff) begin
               any_in = any_fin;
               all_in = all_fin;
            end
            if (k_ff == SW'(SAMPLE_COUNT - 1)) begin
               state_in = ST_FIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_FIN: begin
            deb_in[row_ff] = deb_new;
            bits_in        = deb_new;
            state_in       = ST_DONE;
         end
         ST_WALK: begin
            for (int c = 0; c < NUM_COLS; c++) begin
               if (deb_rd[c] && !ov_v) begin
                  if (n_v == 3'(NUM_SLOTS)) begin
                     ov_v = 1'b1;
                  end else begin
                     key_in[n_v] = keymap_code(layer_ff, walk_ff, 3'(c));
                     n_v         = n_v + 1'b1;
                  end
               end
            end
            cnt_in  = n_v;
            over_in = ov_v;
            if (ov_v || walk_ff == 3'(NUM_ROWS - 1)) begin
               state_in = ST_DONE;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res_data            = '0;
      res_data.active_row = row_ff;
      if (cmd_ff == CMD_SCAN || cmd_ff == CMD_READ) begin
         res_data.row_bits = bits_ff;
      end
      if (cmd_ff == CMD_REPORT) begin
         res_data.modifier  = {6'b0, shift_ff, 1'b0};
         res_data.key_slot0 = over_ff ? ROLLOVER_CODE : key_ff[0];
         res_data.key_slot1 = over_ff ? ROLLOVER_CODE : key_ff[1];
         res_data.key_slot2 = over_ff ? ROLLOVER_CODE : key_ff[2];
         res_data.key_slot3 = over_ff ? ROLLOVER_CODE : key_ff[3];
         res_data.key_slot4 = over_ff ? ROLLOVER_CODE : key_ff[4];
         res_data.key_slot5 = over_ff ? ROLLOVER_CODE : key_ff[5];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         row_ff      <= 3'd0;
         slot_ff     <= '0;
         pend_ff     <= 1'b0;
         shift_ff    <= 1'b0;
         layer_ff    <= 1'b0;
         cmd_ff      <= CMD_SCAN;
         for (int r = 0; r < NUM_ROWS; r++) begin
            deb_ff[r] <= 6'h00;
         end
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         row_ff      <= row_in;
         slot_ff     <= slot_in;
         pend_ff     <= (state_ff == ST_RD);
         shift_ff    <= shift_in;
         layer_ff    <= layer_in;
         cmd_ff      <= cmd_in;
         deb_ff      <= deb_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      any_ff  <= any_in;
      all_ff  <= all_in;
      bits_ff <= bits_in;
      walk_ff <= walk_in;
      cnt_ff  <= cnt_in;
      over_ff <= over_in;
      key_ff  <= key_in;
   end
endmodule

// ----- src/keyboard_matrix_scan_debounce.sv -----
// Top level of the key matrix scanner with debounce and HID report build.
//
//   channel  direction  handshake        item contents
//   req_port in         valid / ready    cmd, column_levels, row_select
//   rsp_port out        valid / ready    active_row, row_bits, modifier, key_slot0..5
//
// A scan tick walks the stored samples of the new row through the shared sample read
// port one per cycle. A report walks the matrix rows in turn, stopping early on
// rollover; a row read goes straight to the result.
// After reset the sample store is cleared, with req ready low.
// Results wait in an output register, so a stalled response holds only the next result.
module keyboard_matrix_scan_debounce #(
   parameter int SAMPLE_COUNT = kmsd_pkg::SAMPLE_COUNT_DEF
) (
   input logic        clock,
   input logic        reset,
   kmsd_req_if.sink   req_port,
   kmsd_rsp_if.source rsp_port
);
   import kmsd_pkg::*;

   logic         res_valid;
   logic         res_ready;
   rsp_data_type res_data;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff;

   kmsd_ctrl #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_port),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   assign res_ready    = !rsp_valid_ff || rsp_port.ready;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.active_row = rsp_data_ff.active_row;
   assign rsp_port.row_bits   = rsp_data_ff.row_bits;
   assign rsp_port.modifier   = rsp_data_ff.modifier;
   assign rsp_port.key_slot0  = rsp_data_ff.key_slot0;
   assign rsp_port.key_slot1  = rsp_data_ff.key_slot1;
   assign rsp_port.key_slot2  = rsp_data_ff.key_slot2;
   assign rsp_port.key_slot3  = rsp_data_ff.key_slot3;
   assign rsp_port.key_slot4  = rsp_data_ff.key_slot4;
   assign rsp_port.key_slot5  = rsp_data_ff.key_slot5;
endmodule

// ----- src/kmsd_checker.sv -----
// Port-level assertions for the key matrix scanner, bound to the top level.
module kmsd_port_props (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] active_row,
   input logic [7:0] modifier,
   input logic [7:0] key_slot0,
   input logic [7:0] key_slot5
);
   import kmsd_pkg::*;

   // The block works on one item at a time, so it cannot take two in a row.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on consecutive cycles");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> active_row < 3'(NUM_ROWS))
      else $error("active row out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (modifier & 8'hfd) == 8'h00)
      else $error("modifier has bits other than shift");

   // No keymap entry is the rollover code, so slot 0 showing it means all slots do.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && key_slot0 == ROLLOVER_CODE |-> key_slot5 == ROLLOVER_CODE)
      else $error("partial rollover report");
endmodule

bind keyboard_matrix_scan_debounce kmsd_port_props u_port_props (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .active_row (rsp_port.active_row),
   .modifier   (rsp_port.modifier),
   .key_slot0  (rsp_port.key_slot0),
   .key_slot5  (rsp_port.key_slot5)
);

// ----- dv/kmsd_checker.sv -----
// Checker that mirrors the key matrix scanner, predicts every result and compares it.
`timescale 1ns / 1ps
module kmsd_checker #(
   parameter int SAMPLE_COUNT = kmsd_pkg::SAMPLE_COUNT_DEF
) (
   input  logic clock,
   input  logic reset,
   kmsd_req_if  req_mon,
   kmsd_rsp_if  rsp_mon,
   output int   fail_count,
   output int   results_owed
);
   import kmsd_pkg::*;

   logic [7:0] key_codes [2][NUM_ROWS][NUM_COLS] = '{
      '{'{8'h2C, 8'h36, 8'h10, 8'h11, 8'h05, 8'h51},
        '{8'h28, 8'h0F, 8'h0E, 8'h0D, 8'h0B, 8'h50},
        '{8'h13, 8'h12, 8'h0C, 8'h18, 8'h1C, 8'h52},
        '{8'h2A, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h4F},
        '{8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h29},
        '{8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'hE2}},
      '{'{8'h2C, 8'h33, 8'h10, 8'h11, 8'h05, 8'h51},
        '{8'h28, 8'h2D, 8'h0E, 8'h0D, 8'h0B, 8'h50},
        '{8'h27, 8'h26, 8'h25, 8'h24, 8'h23, 8'h52},
        '{8'h2E, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h4F},
        '{8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h39},
        '{8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'hE2}}
   };

   logic [5:0]   samples [NUM_ROWS][SAMPLE_COUNT];
   logic [5:0]   pressed [NUM_ROWS];
   int           row_ptr;
   int           slot_ptr;
   logic         shift_on;
   logic         layer_alt;
   rsp_data_type awaited_results [$];
   int           reqs_taken;
   int           rsps_taken;

   assign results_owed = reqs_taken - rsps_taken;

   function automatic rsp_data_type compute_scanner_result(input logic [1:0] cmd,
                                                           input logic [5:0] levels,
                                                           input logic [2:0] sel);
      rsp_data_type res;
      logic [5:0]   any_on;
      logic [5:0]   all_on;
      logic [7:0]   codes [NUM_SLOTS];
      int           n;
      res = '0;
      n   = 0;
      foreach (codes[k]) codes[k] = 8'h00;
      unique case (cmd)
         CMD_SCAN: begin
            samples[row_ptr][slot_ptr] = ~levels;
            if (row_ptr == NUM_ROWS - 1) begin
               row_ptr  = 0;
               slot_ptr = (slot_ptr == SAMPLE_COUNT - 1) ? 0 : slot_ptr + 1;
            end else begin
               row_ptr++;
            end
            any_on = '0;
            all_on = ROW_MASK;
            for (int s = 0; s < SAMPLE_COUNT; s++) begin
               any_on |= samples[row_ptr][s];
               all_on &= samples[row_ptr][s];
            end
            // A key changes state only once every stored sample agrees.
            pressed[row_ptr] = (all_on | pressed[row_ptr]) & any_on;
            res.row_bits     = pressed[row_ptr];
         end
         CMD_REPORT: begin
            if (pressed[ALT_KEY_ROW][ARROW_COL]) begin
               if (pressed[UP_KEY_ROW][ARROW_COL]) shift_on = 1'b1;
               else if (pressed[DOWN_KEY_ROW][ARROW_COL]) shift_on = 1'b0;
               if (pressed[RIGHT_KEY_ROW][ARROW_COL]) layer_alt = 1'b1;
               else if (pressed[LEFT_KEY_ROW][ARROW_COL]) layer_alt = 1'b0;
               pressed[UP_KEY_ROW][ARROW_COL]    = 1'b0;
               pressed[DOWN_KEY_ROW][ARROW_COL]  = 1'b0;
               pressed[RIGHT_KEY_ROW][ARROW_COL] = 1'b0;
               pressed[LEFT_KEY_ROW][ARROW_COL]  = 1'b0;
            end
            res.modifier = {6'b0, shift_on, 1'b0};
            for (int r = 0; r < NUM_ROWS; r++) begin
               for (int c = 0; c < NUM_COLS; c++) begin
                  if (pressed[r][c]) begin
                     if (n < NUM_SLOTS) codes[n] = key_codes[layer_alt][r][c];
                     n++;
                  end
               end
            end
            if (n > NUM_SLOTS) foreach (codes[k]) codes[k] = ROLLOVER_CODE;
            res.key_slot0 = codes[0];
            res.key_slot1 = codes[1];
            res.key_slot2 = codes[2];
            res.key_slot3 = codes[3];
            res.key_slot4 = codes[4];
            res.key_slot5 = codes[5];
         end
         CMD_READ: begin
            res.row_bits = (sel < NUM_ROWS) ? pressed[sel] : 6'h00;
         end
         default: begin
         end
      endcase
      res.active_row = 3'(row_ptr);
      return res;
   endfunction

   task automatic check_field(input string label, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         if (fail_count < 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_data_type want;
      if (reset) begin
         foreach (samples[r, s]) samples[r][s] = '0;
         foreach (pressed[r]) pressed[r] = '0;
         row_ptr    = 0;
         slot_ptr   = 0;
         shift_on   = 1'b0;
         layer_alt  = 1'b0;
         fail_count = 0;
         awaited_results.delete();
         reqs_taken <= 0;
         rsps_taken <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            awaited_results.push_back(compute_scanner_result(req_mon.cmd,
                                                             req_mon.column_levels,
                                                             req_mon.row_select));
            reqs_taken <= reqs_taken + 1;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsps_taken <= rsps_taken + 1;
            if (awaited_results.size() == 0) begin
               if (fail_count < 10) $display("%0t: result item with none awaited", $time);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("active_row", want.active_row, rsp_mon.active_row);
               check_field("row_bits", want.row_bits, rsp_mon.row_bits);
               check_field("modifier", want.modifier, rsp_mon.modifier);
               check_field("key_slot0", want.key_slot0, rsp_mon.key_slot0);
               check_field("key_slot1", want.key_slot1, rsp_mon.key_slot1);
               check_field("key_slot2", want.key_slot2, rsp_mon.key_slot2);
               check_field("key_slot3", want.key_slot3, rsp_mon.key_slot3);
               check_field("key_slot4", want.key_slot4, rsp_mon.key_slot4);
               check_field("key_slot5", want.key_slot5, rsp_mon.key_slot5);
            end
         end
      end
   end

endmodule

// ----- dv/keyboard_matrix_scan_debounce_tb.sv -----
// Top of the key matrix scanner testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module keyboard_matrix_scan_debounce_tb;
   import kmsd_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         EPISODES     = 9;
   localparam int         LONG_HOLD    = 150;
   localparam int         IDLE_LIMIT   = 2000;
   localparam int         DRAIN_CYCLES = 32;

   typedef enum int {
      PAT_ROLLOVER,
      PAT_SHIFT_LAYER_ON,
      PAT_SHIFT_LAYER_OFF,
      PAT_FEW_KEYS,
      PAT_ALT_RANDOM,
      PAT_RELEASED
   } key_pattern_type;

   logic       clock = 1'b0;
   logic       reset;
   int         fail_count;
   int         results_owed;
   int         quiet_cycles = 0;
   logic [2:0] scan_pos = 3'd0;
   bit         sender_idles = 1'b1;
   bit         long_hold_wanted = 1'b0;

   kmsd_req_if req_ch ();
   kmsd_rsp_if rsp_ch ();

   keyboard_matrix_scan_debounce u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   kmsd_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Valid is lowered only when a gap follows, so back-to-back items keep it high.
   task automatic offer_item(input logic [1:0] cmd, input logic [5:0] levels,
                             input logic [2:0] sel);
      int gap;
      gap = sender_idles ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.cmd           <= cmd;
      req_ch.column_levels <= levels;
      req_ch.row_select    <= sel;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (cmd == CMD_SCAN) scan_pos = (scan_pos == 3'd5) ? 3'd0 : scan_pos + 3'd1;
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   initial begin
      int  hold;
      int  served;
      bit  rsp_idles;
      served    = 0;
      rsp_idles = 1'b1;
      forever begin
         if (served % 40 == 0) rsp_idles = ($urandom_range(0, 3) != 0);
         if (long_hold_wanted) begin
            hold             = LONG_HOLD;
            long_hold_wanted = 1'b0;
         end else begin
            hold = rsp_idles ? $urandom_range(0, 9) : 0;
         end
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         served++;
      end
   end

   initial begin
      logic [5:0]      held [NUM_ROWS];
      logic [5:0]      levels;
      key_pattern_type kind;
      int              span;
      int              pick;
      req_ch.valid         <= 1'b0;
      req_ch.cmd           <= CMD_SCAN;
      req_ch.column_levels <= ROW_MASK;
      req_ch.row_select    <= 3'd0;
      reset                <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      offer_item(CMD_REPORT, ROW_MASK, 3'd0);
      offer_item(CMD_SCAN, 6'h00, 3'd7);
      offer_item(CMD_SCAN, ROW_MASK, 3'd0);
      offer_item(CMD_SCAN, 6'h2A, 3'd5);
      offer_item(CMD_SCAN, 6'h15, 3'd2);
      // Rows six and seven lie outside the matrix and must read as empty.
      for (int r = 0; r < 8; r++) offer_item(CMD_READ, 6'($urandom), 3'(r));
      offer_item(CMD_UNUSED, ROW_MASK, 3'd7);
      offer_item(CMD_UNUSED, 6'h00, 3'd0);
      repeat (6) offer_item(CMD_SCAN, 6'h00, 3'd0);
      offer_item(CMD_REPORT, 6'h00, 3'd7);

      for (int ep = 0; ep < EPISODES; ep++) begin
         kind         = (ep < 3) ? key_pattern_type'(ep)
                                 : key_pattern_type'($urandom_range(0, 5));
         sender_idles = ($urandom_range(0, 3) != 0);
         if (ep == 3) begin
            // Keep offering while the receiver holds off, so the block backs up.
            sender_idles     = 1'b0;
            long_hold_wanted = 1'b1;
         end
         if (ep == 6) wait_for_results();
         foreach (held[r]) held[r] = '0;
         unique case (kind)
            PAT_ROLLOVER: begin
               foreach (held[r]) held[r] = 6'($urandom) | 6'h03;
            end
            PAT_SHIFT_LAYER_ON: begin
               held[ALT_KEY_ROW][ARROW_COL]   = 1'b1;
               held[UP_KEY_ROW][ARROW_COL]    = 1'b1;
               held[RIGHT_KEY_ROW][ARROW_COL] = 1'b1;
               held[4][$urandom_range(0, 4)]  = 1'b1;
            end
            PAT_SHIFT_LAYER_OFF: begin
               held[ALT_KEY_ROW][ARROW_COL]  = 1'b1;
               held[DOWN_KEY_ROW][ARROW_COL] = 1'b1;
               held[LEFT_KEY_ROW][ARROW_COL] = 1'b1;
               held[2][$urandom_range(0, 4)] = 1'b1;
            end
            PAT_FEW_KEYS: begin
               repeat ($urandom_range(1, 6))
                  held[$urandom_range(0, 5)][$urandom_range(0, 5)] = 1'b1;
            end
            PAT_ALT_RANDOM: begin
               held[ALT_KEY_ROW][ARROW_COL] = 1'b1;
               for (int r = 0; r < 4; r++) held[r][ARROW_COL] = 1'($urandom_range(0, 1));
               held[$urandom_range(0, 5)][$urandom_range(0, 4)] = 1'b1;
            end
            default: begin
            end
         endcase
         span = $urandom_range(40, 55);
         for (int i = 0; i < span; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               // Now and then a bouncing contact gives a random sample.
               levels = ($urandom_range(0, 11) == 0) ? 6'($urandom) : ~held[scan_pos];
               offer_item(CMD_SCAN, levels, 3'($urandom));
            end else if (pick < 85) begin
               offer_item(CMD_REPORT, 6'($urandom), 3'($urandom));
            end else if (pick < 97) begin
               offer_item(CMD_READ, 6'($urandom), 3'($urandom));
            end else begin
               offer_item(CMD_UNUSED, 6'($urandom), 3'($urandom));
            end
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && results_owed == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
